// ===== rtl/core/thp_sensor_compensation_core_defines.svh =====
// Assertion macros used by the checker file
`ifndef THP_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define THP_SENSOR_COMPENSATION_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define THP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define THP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/thp_pkg.sv =====
// ----------------------------------------------------------------------------
// thp_pkg
// Shared types, register indexes and constants for the compensation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package thp_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 64;
    localparam int unsigned DivStages = 32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TEMP       = 3'd0,
        REG_PRESS_LOW  = 3'd1,
        REG_PRESS_MID  = 3'd2,
        REG_PRESS_LAST = 3'd3,
        REG_HUM_MAIN   = 3'd4,
        REG_HUM_OFS    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [31:0]        pressure;
        logic [16:0]        humidity;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0]  index;
        logic [CfgDataW-1:0] data;
    } t_cfg_item;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] a, input int unsigned s);
        asr32 = 32'($signed(a) >>> s);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        mul32 = p[31:0];
    endfunction
endpackage

// ===== rtl/core/thp_if.sv =====
// ----------------------------------------------------------------------------
// thp_if
// Valid/ready channels for input items, results and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface thp_in_if;
    import thp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface thp_out_if;
    import thp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface thp_cfg_if;
    import thp_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/thp_div.sv =====
// ----------------------------------------------------------------------------
// thp_div
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module thp_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    input  logic [31:0] i_side,
    output logic [31:0] o_quot,
    output logic [31:0] o_side
);
    import thp_pkg::*;

    logic [31:0] r_rem  [DivStages];
    logic [31:0] r_num  [DivStages];
    logic [31:0] r_den  [DivStages];
    logic [31:0] r_side [DivStages];

    // stage inputs: the port for the first stage, the previous stage after that
    logic [31:0] w_rp [DivStages];
    logic [31:0] w_np [DivStages];
    logic [31:0] w_dp [DivStages];
    logic [31:0] w_sp [DivStages];

    always_comb begin
        w_rp[0] = 32'd0;
        w_np[0] = i_num;
        w_dp[0] = i_den;
        w_sp[0] = i_side;
        for (int s = 1; s < DivStages; s++) begin
            w_rp[s] = r_rem[s-1];
            w_np[s] = r_num[s-1];
            w_dp[s] = r_den[s-1];
            w_sp[s] = r_side[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DivStages; s++) begin
                logic [32:0] t;
                t = {w_rp[s], w_np[s][31]};
                if (t >= {1'b0, w_dp[s]}) begin
                    r_rem[s] <= 32'(t - {1'b0, w_dp[s]});
                    r_num[s] <= {w_np[s][30:0], 1'b1};
                end else begin
                    r_rem[s] <= t[31:0];
                    r_num[s] <= {w_np[s][30:0], 1'b0};
                end
                r_den[s]  <= w_dp[s];
                r_side[s] <= w_sp[s];
            end
        end
    end

    assign o_quot = r_num[DivStages-1];
    assign o_side = r_side[DivStages-1];
endmodule

// ===== rtl/core/thp_sensor_compensation_core.sv =====
// ----------------------------------------------------------------------------
// thp_sensor_compensation_core
// Integer temperature, pressure and humidity compensation pipeline.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipe stalls only when the output
// register is full and not taken. Divider is 32 stages, one bit each.
// Reset: synchronous active low, clears valid bits and coefficients to zero.
`timescale 1ns / 1ps
module thp_sensor_compensation_core (
    input  logic i_clk,
    input  logic i_rst_n,
    thp_in_if.sink    i_in,
    thp_out_if.source o_out,
    thp_cfg_if.sink   i_cfg
);
    import thp_pkg::*;

    localparam int unsigned PreStages = 8;
    localparam int unsigned PostStages = 3;
    localparam int unsigned Depth = PreStages + DivStages + PostStages;

    logic [47:0] r_tc;
    logic [63:0] r_pl, r_pm;
    logic [15:0] r_p9;
    logic [39:0] r_hm;
    logic [23:0] r_ho;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0; r_pl <= '0; r_pm <= '0; r_p9 <= '0; r_hm <= '0; r_ho <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_TEMP:       r_tc <= i_cfg.data.data[47:0];
                REG_PRESS_LOW:  r_pl <= i_cfg.data.data;
                REG_PRESS_MID:  r_pm <= i_cfg.data.data;
                REG_PRESS_LAST: r_p9 <= i_cfg.data.data[15:0];
                REG_HUM_MAIN:   r_hm <= i_cfg.data.data[39:0];
                REG_HUM_OFS:    r_ho <= i_cfg.data.data[23:0];
                default: ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    always_comb begin
        t1 = {16'd0, r_tc[15:0]};
        t2 = 32'($signed(r_tc[31:16]));
        t3 = 32'($signed(r_tc[47:32]));
        p1 = {16'd0, r_pl[15:0]};
        p2 = 32'($signed(r_pl[31:16]));
        p3 = 32'($signed(r_pl[47:32]));
        p4 = 32'($signed(r_pl[63:48]));
        p5 = 32'($signed(r_pm[15:0]));
        p6 = 32'($signed(r_pm[31:16]));
        p7 = 32'($signed(r_pm[47:32]));
        p8 = 32'($signed(r_pm[63:48]));
        p9 = 32'($signed(r_p9));
        h1 = {24'd0, r_hm[7:0]};
        h2 = 32'($signed(r_hm[23:8]));
        h3 = {24'd0, r_hm[31:24]};
        h6 = 32'($signed(r_hm[39:32]));
        h4 = 32'($signed(r_ho[11:0]));
        h5 = 32'($signed(r_ho[23:12]));
    end

    // global stall: advance only while the output register can take data
    logic w_adv;
    logic r_ov;
    logic [Depth-1:0] r_vld;
    assign w_adv = !r_ov || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_adv) r_vld <= {r_vld[Depth-2:0], i_in.valid};
    end

    // ---- pre-divide stages ----
    logic [31:0] r0_at, r0_ap, r0_ah, r0_a, r0_d;
    logic [31:0] r1_v1, r1_dd, r1_ap, r1_ah;
    logic [31:0] r2_tf, r2_ap, r2_ah;
    logic [31:0] r3_tf, r3_v1, r3_q, r3_hv, r3_ap, r3_ah;
    logic [31:0] r4_tf, r4_a, r4_b, r4_c, r4_d, r4_e, r4_hv, r4_hs, r4_ap, r4_ah;
    logic [31:0] r5_tf, r5_v2, r5_v1, r5_ap, r5_ha, r5_hb, r5_hc;
    logic [31:0] r6_tf, r6_v2, r6_v1, r6_ap, r6_ha, r6_he;
    logic [31:0] r7_tf, r7_num, r7_v1, r7_ha, r7_hf;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_at <= {12'd0, i_in.data.raw_temp};
            r0_ap <= {12'd0, i_in.data.raw_press};
            r0_ah <= {16'd0, i_in.data.raw_hum};
            r0_a  <= ({12'd0, i_in.data.raw_temp} >> 3) - (t1 << 1);
            r0_d  <= ({12'd0, i_in.data.raw_temp} >> 4) - t1;
            // stage 1
            r1_v1 <= asr32(mul32(r0_a, t2), 11);
            r1_dd <= asr32(mul32(r0_d, r0_d), 12);
            r1_ap <= r0_ap; r1_ah <= r0_ah;
            // stage 2
            r2_tf <= r1_v1 + asr32(mul32(r1_dd, t3), 14);
            r2_ap <= r1_ap; r2_ah <= r1_ah;
            // stage 3
            r3_tf <= r2_tf;
            r3_v1 <= asr32(r2_tf, 1) - 32'd64000;
            r3_q  <= mul32(asr32(asr32(r2_tf, 1) - 32'd64000, 2),
                           asr32(asr32(r2_tf, 1) - 32'd64000, 2));
            r3_hv <= r2_tf - 32'd76800;
            r3_ap <= r2_ap; r3_ah <= r2_ah;
            // stage 4: independent products
            r4_tf <= r3_tf;
            r4_a  <= mul32(asr32(r3_q, 11), p6);
            r4_b  <= mul32(r3_v1, p5) << 1;
            r4_c  <= mul32(p3, asr32(r3_q, 13));
            r4_d  <= mul32(p2, r3_v1);
            r4_e  <= mul32(h5, r3_hv);
            r4_hs <= mul32(r3_hv, h6);
            r4_hv <= asr32(mul32(r3_hv, h3), 11) + 32'd32768;
            r4_ap <= r3_ap; r4_ah <= r3_ah;
            // stage 5
            r5_tf <= r4_tf;
            r5_v2 <= asr32(r4_a + r4_b, 2) + (p4 << 16);
            r5_v1 <= asr32(asr32(r4_c, 3) + asr32(r4_d, 1), 18) + 32'd32768;
            r5_ap <= r4_ap;
            r5_ha <= asr32((r4_ah << 14) - (h4 << 20) - r4_e + 32'd16384, 15);
            r5_hb <= asr32(r4_hs, 10);
            r5_hc <= r4_hv;
            // stage 6
            r6_tf <= r5_tf;
            r6_v2 <= r5_v2;
            r6_v1 <= asr32(mul32(r5_v1, p1), 15);
            r6_ap <= r5_ap;
            r6_ha <= r5_ha;
            r6_he <= asr32(mul32(r5_hb, r5_hc), 10) + 32'd2097152;
            // stage 7
            r7_tf <= r6_tf;
            r7_v1 <= r6_v1;
            r7_num <= mul32((32'd1048576 - r6_ap) - asr32(r6_v2, 12), 32'd3125);
            r7_ha <= r6_ha;
            r7_hf <= asr32(mul32(r6_he, h2) + 32'd8192, 14);
        end
    end

    // hold fine temperature and the humidity product in delay lines beside
    // the divider; the side channel carries the divisor for the zero check
    logic [31:0] r_tfd [DivStages];
    logic [31:0] r_hd  [DivStages];
    logic [31:0] w_dnum, w_dden, w_quot, w_side;
    logic        r_hiq [DivStages];
    assign w_dnum = r7_num[31] ? r7_num : (r7_num << 1);
    assign w_dden = r7_v1;

    thp_div u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_dnum),
        .i_den (w_dden),
        .i_side(r7_v1),
        .o_quot(w_quot),
        .o_side(w_side)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tfd[0] <= r7_tf;
            r_hd[0]  <= mul32(r7_ha, r7_hf);
            for (int s = 1; s < DivStages; s++) begin
                r_tfd[s] <= r_tfd[s-1];
                r_hd[s]  <= r_hd[s-1];
            end
            r_hiq[0] <= r7_num[31];
            for (int s = 1; s < DivStages; s++) r_hiq[s] <= r_hiq[s-1];
        end
    end

    // ---- post-divide stages ----
    logic [31:0] r8_p, r8_tf, r8_h, r8_a, r8_b;
    logic        r8_z;
    logic [31:0] r9_p, r9_tf, r9_h, r9_m1, r9_m2, r9_q;
    logic        r9_z;
    logic [31:0] r10_p, r10_tf, r10_h;
    logic [31:0] w_pq;
    assign w_pq = r_hiq[DivStages-1] ? (w_quot << 1) : w_quot;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_p  <= w_pq;
            r8_z  <= (w_side == 32'd0);
            r8_tf <= r_tfd[DivStages-1];
            r8_h  <= r_hd[DivStages-1];
            r8_a  <= mul32(w_pq >> 3, w_pq >> 3) >> 13;
            r8_b  <= asr32(mul32(w_pq >> 2, p8), 13);
            // stage 9
            r9_p  <= r8_p; r9_z <= r8_z; r9_tf <= r8_tf; r9_h <= r8_h;
            r9_m1 <= asr32(mul32(p9, r8_a), 12) + r8_b;
            r9_q  <= mul32(asr32(r8_h, 15), asr32(r8_h, 15));
            r9_m2 <= mul32(r8_tf, 32'd5) + 32'd128;
            // stage 10
            r10_p  <= r9_z ? 32'd0 : r9_p + asr32(r9_m1 + p7, 4);
            r10_tf <= asr32(r9_m2, 8);
            r10_h  <= r9_h - asr32(mul32(asr32(r9_q, 7), h1), 4);
        end
    end

    logic [31:0] w_hc;
    always_comb begin
        priority if (r10_h[31]) w_hc = 32'd0;
        else if (r10_h > 32'd419430400) w_hc = 32'd419430400;
        else w_hc = r10_h;
    end

    t_out_item r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= r_vld[Depth-1];
        if (w_adv) begin
            r_out.temperature <= r10_tf;
            r_out.pressure    <= r10_p;
            r_out.humidity    <= w_hc[28:12];
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
endmodule

// ===== rtl/core/thp_checker.sv =====
// ----------------------------------------------------------------------------
// thp_checker
// Port-level checks for the compensation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "thp_sensor_compensation_core_defines.svh"
module thp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        o_out_valid,
    input logic        o_out_ready,
    input logic [16:0] o_hum
);
    `THP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !o_out_ready, o_out_valid)
    `THP_ASSERT_IMPL(a_hrange, i_clk, i_rst_n, o_out_valid, o_hum <= 17'd102400)
    `THP_ASSERT_IMPL(a_rdy, i_clk, i_rst_n, !o_out_valid || o_out_ready, i_in_ready)
    `THP_ASSERT_IMPL(a_stall, i_clk, i_rst_n, o_out_valid && !o_out_ready && i_in_valid,
        !i_in_ready)
endmodule

bind thp_sensor_compensation_core thp_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .o_out_valid(o_out.valid),
    .o_out_ready(o_out.ready),
    .o_hum      (o_out.data.humidity)
);
